// ----- rtl/core/tftpdf_pkg.sv -----
`default_nettype none
package tftpdf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned KindW  = 4;

  // tftp opcodes
  localparam logic [WordW-1:0] OpRrq   = 16'd1;
  localparam logic [WordW-1:0] OpWrq   = 16'd2;
  localparam logic [WordW-1:0] OpData  = 16'd3;
  localparam logic [WordW-1:0] OpAck   = 16'd4;
  localparam logic [WordW-1:0] OpError = 16'd5;
  localparam logic [WordW-1:0] OpBare6 = 16'd6;
  localparam logic [WordW-1:0] OpStr7  = 16'd7;
  localparam logic [WordW-1:0] OpStr8  = 16'd8;
  localparam logic [WordW-1:0] OpFlag  = 16'd9;
  localparam logic [WordW-1:0] OpBare10 = 16'd10;

  localparam logic [WordW-1:0] IllegalOpCode = 16'd4;

  typedef enum logic [KindW-1:0] {
    K_BARE  = 4'd0,
    K_LEN   = 4'd1,
    K_BLOCK = 4'd2,
    K_CODE  = 4'd3,
    K_FLAG  = 4'd4,
    K_SBYTE = 4'd5,
    K_DBYTE = 4'd6,
    K_SEND  = 4'd7,
    K_BADOP = 4'd8
  } kind_t;

  // one field event
  typedef struct packed {
    logic [WordW-1:0] opcode;
    kind_t            kind;
    logic [WordW-1:0] value;
    logic             last;
  } event_t;

endpackage
`default_nettype wire

// ----- rtl/core/tftpdf_front.sv -----
`default_nettype none
module tftpdf_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      accept,
  input  wire logic [7:0]                in_byte,
  output logic                           ev_valid,
  output tftpdf_pkg::event_t             ev
);
  import tftpdf_pkg::*;

  typedef enum logic [3:0] {
    PH_OP_HI   = 4'd0,
    PH_OP_LO   = 4'd1,
    PH_LEN_HI  = 4'd2,
    PH_LEN_LO  = 4'd3,
    PH_BLK_HI  = 4'd4,
    PH_BLK_LO  = 4'd5,
    PH_DATA    = 4'd6,
    PH_CODE_HI = 4'd7,
    PH_CODE_LO = 4'd8,
    PH_FLAG    = 4'd9,
    PH_STRING  = 4'd10
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [WordW-1:0]  opcode_r, opcode_nxt;
  logic [ByteW-1:0]  held_r, held_nxt;
  logic [WordW-1:0]  len_r, len_nxt;
  logic [WordW-1:0]  seen_r, seen_nxt;
  logic [WordW-1:0]  word;
  logic [WordW-1:0]  seen_inc;
  logic              hit;
  event_t            e;

  assign word     = {held_r, in_byte};
  assign seen_inc = seen_r + WordW'(1);

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    held_nxt   = held_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    hit        = 1'b0;
    e.opcode   = opcode_r;
    e.kind     = K_BARE;
    e.value    = '0;
    e.last     = 1'b0;
    unique case (phase_r)
      PH_OP_LO: begin
        opcode_nxt = word;
        e.opcode   = word;
        held_nxt   = '0;
        if (word == OpBare6 || word == OpBare10) begin
          hit    = 1'b1;
          e.last = 1'b1;
        end else if (word == OpRrq || word == OpWrq || word == OpStr7 || word == OpStr8) begin
          phase_nxt = PH_STRING;
        end else if (word == OpData) begin
          phase_nxt = PH_LEN_HI;
        end else if (word == OpAck) begin
          phase_nxt = PH_BLK_HI;
        end else if (word == OpError) begin
          phase_nxt = PH_CODE_HI;
        end else if (word == OpFlag) begin
          phase_nxt = PH_FLAG;
        end else begin
          hit     = 1'b1;
          e.kind  = K_BADOP;
          e.value = IllegalOpCode;
          e.last  = 1'b1;
        end
      end
      PH_LEN_HI, PH_BLK_HI, PH_CODE_HI: begin
        held_nxt  = in_byte;
        phase_nxt = phase_t'(phase_r + 4'd1);
      end
      PH_LEN_LO: begin
        len_nxt   = word;
        held_nxt  = '0;
        phase_nxt = PH_BLK_HI;
        hit       = 1'b1;
        e.kind    = K_LEN;
        e.value   = word;
      end
      PH_BLK_LO: begin
        held_nxt = '0;
        hit      = 1'b1;
        e.kind   = K_BLOCK;
        e.value  = word;
        if (opcode_r == OpData && len_r != '0) begin
          phase_nxt = PH_DATA;
        end else begin
          e.last = 1'b1;
        end
      end
      PH_DATA: begin
        seen_nxt = seen_inc;
        hit      = 1'b1;
        e.kind   = K_DBYTE;
        e.value  = WordW'(in_byte);
        e.last   = (seen_inc == len_r);
      end
      PH_CODE_LO: begin
        held_nxt  = '0;
        phase_nxt = PH_STRING;
        hit       = 1'b1;
        e.kind    = K_CODE;
        e.value   = word;
      end
      PH_FLAG: begin
        phase_nxt = PH_STRING;
        hit       = 1'b1;
        e.kind    = K_FLAG;
        e.value   = WordW'(in_byte);
      end
      PH_STRING: begin
        hit = 1'b1;
        if (in_byte == '0) begin
          e.kind = K_SEND;
          e.last = 1'b1;
        end else begin
          e.kind  = K_SBYTE;
          e.value = WordW'(in_byte);
        end
      end
      default: begin
        held_nxt  = in_byte;
        phase_nxt = PH_OP_LO;
      end
    endcase
    // every packet leaves the parser in its reset state
    if (hit && e.last) begin
      phase_nxt  = PH_OP_HI;
      opcode_nxt = '0;
      held_nxt   = '0;
      len_nxt    = '0;
      seen_nxt   = '0;
    end
  end

  assign ev_valid = accept && hit;
  assign ev       = e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OP_HI;
      opcode_r <= '0;
      held_r   <= '0;
      len_r    <= '0;
      seen_r   <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      held_r   <= held_nxt;
      len_r    <= len_nxt;
      seen_r   <= seen_nxt;
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_valid && ev.last) |=> (phase_r == PH_OP_HI && seen_r == '0 && len_r == '0))
    else $error("parser not cleared after packet end");

  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (len_r != '0 && seen_r != len_r))
    else $error("data count out of range");

endmodule
`default_nettype wire

// ----- rtl/core/tftpdf_queue.sv -----
`default_nettype none
module tftpdf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire tftpdf_pkg::event_t   wr_data,
  input  wire logic                 rd_en,
  output tftpdf_pkg::event_t        rd_data,
  output logic                      has_data,
  output logic                      is_full
);
  import tftpdf_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  event_t             mem_r [DEPTH];
  logic [PtrW-1:0]    wptr_r, rptr_r;
  logic [CntW-1:0]    count_r;

  assign has_data = (count_r != '0);
  assign is_full  = (count_r == CntW'(DEPTH));
  assign rd_data  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= (wptr_r == PtrW'(DEPTH - 1)) ? '0 : wptr_r + PtrW'(1);
      end
      if (rd_en) begin
        rptr_r <= (rptr_r == PtrW'(DEPTH - 1)) ? '0 : rptr_r + PtrW'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + CntW'(1);
        2'b01:   count_r <= count_r - CntW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (is_full && !rd_en) |-> !wr_en)
    else $error("write into full event queue");

endmodule
`default_nettype wire

// ----- rtl/core/tftpdf_back.sv -----
`default_nettype none
module tftpdf_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_has_data,
  input  wire tftpdf_pkg::event_t   q_data,
  output logic                      q_rd,
  input  wire logic                 pop,
  output logic                      empty,
  output tftpdf_pkg::event_t        out_ev
);
  import tftpdf_pkg::*;

  logic   valid_r;
  event_t ev_r;

  assign q_rd   = q_has_data && (!valid_r || pop);
  assign empty  = !valid_r;
  assign out_ev = ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_rd) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      ev_r <= q_data;
    end
  end

  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (!valid_r && q_has_data) |=> valid_r)
    else $error("output stage idle while events wait");

endmodule
`default_nettype wire

// ----- rtl/core/tftp_style_packet_deframer_core.sv -----
`default_nettype none
// an event is written into the event queue when its byte is accepted, then moves into the registered output stage
// throughput: one byte per clock; push is blocked only while the event queue is full
// header high bytes and opcode high byte produce no event
// reset: synchronous active-low rst_n clears the parse state, the event queue and the output stage
// after reset the core accepts bytes at once, expecting an opcode high byte
module tftp_style_packet_deframer_core #(
  parameter int unsigned QDEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte input, queue style
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  // event output, queue style
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      out_packet_opcode,
  output logic [3:0]       out_item_kind,
  output logic [15:0]      out_item_value,
  output logic             out_last_of_packet
);
  import tftpdf_pkg::*;

  logic   accept;
  logic   ev_valid;
  event_t ev;
  event_t q_data;
  logic   q_has_data;
  logic   q_full;
  logic   q_rd;
  event_t out_ev;

  // a byte is taken whenever the queue can hold its possible event
  assign full   = q_full;
  assign accept = push && !q_full;

  // front: phase tracking and field classification, one byte per clock while the queue is not full
  tftpdf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_byte  (in_byte),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  // short queue decouples parsing from the downstream consumer
  tftpdf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (ev_valid),
    .wr_data  (ev),
    .rd_en    (q_rd),
    .rd_data  (q_data),
    .has_data (q_has_data),
    .is_full  (q_full)
  );

  // back: registered output item, refilled in the same clock it is popped when the queue holds an event
  tftpdf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_has_data (q_has_data),
    .q_data     (q_data),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .out_ev     (out_ev)
  );

  assign out_packet_opcode  = out_ev.opcode;
  assign out_item_kind      = out_ev.kind;
  assign out_item_value     = out_ev.value;
  assign out_last_of_packet = out_ev.last;

  // bad opcode items always carry the illegal operation code and end the packet
  a_badop_item: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_ev.kind == K_BADOP) |-> (out_ev.value == IllegalOpCode && out_ev.last))
    else $error("bad opcode item malformed");

endmodule
`default_nettype wire

// ----- tb/tftpdf_checker.sv -----
`default_nettype none
module tftpdf_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [15:0] out_packet_opcode,
  input  wire logic [3:0]  out_item_kind,
  input  wire logic [15:0] out_item_value,
  input  wire logic        out_last_of_packet,
  output int unsigned      mismatch_count,
  output int unsigned      events_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tftpdf_pkg::*;

  typedef enum logic [3:0] {
    S_OP_HI   = 4'd0,
    S_OP_LO   = 4'd1,
    S_LEN_HI  = 4'd2,
    S_LEN_LO  = 4'd3,
    S_BLK_HI  = 4'd4,
    S_BLK_LO  = 4'd5,
    S_DATA    = 4'd6,
    S_CODE_HI = 4'd7,
    S_CODE_LO = 4'd8,
    S_FLAG    = 4'd9,
    S_STRING  = 4'd10
  } parse_state_t;

  parse_state_t     state_q;
  logic [15:0]      opcode_q;
  logic [7:0]       hi_byte_q;
  logic [15:0]      data_len_q;
  logic [15:0]      data_cnt_q;
  event_t           expected_events[$];

  function automatic void clear_parser();
    state_q    = S_OP_HI;
    opcode_q   = '0;
    hi_byte_q  = '0;
    data_len_q = '0;
    data_cnt_q = '0;
  endfunction

  // one byte through the parser model, returns 1 when it yields an event
  function automatic bit deframe_byte(input logic [7:0] b, output event_t ev);
    logic [15:0] word;
    bit          hit;
    word     = {hi_byte_q, b};
    ev       = '0;
    ev.opcode = opcode_q;
    hit      = 1'b1;
    case (state_q)
      S_OP_LO: begin
        opcode_q  = word;
        ev.opcode = word;
        hi_byte_q = '0;
        hit       = 1'b0;
        case (word)
          OpBare6, OpBare10: begin
            hit = 1'b1; ev.kind = K_BARE; ev.last = 1'b1;
          end
          OpRrq, OpWrq, OpStr7, OpStr8: state_q = S_STRING;
          OpData:  state_q = S_LEN_HI;
          OpAck:   state_q = S_BLK_HI;
          OpError: state_q = S_CODE_HI;
          OpFlag:  state_q = S_FLAG;
          default: begin
            hit = 1'b1; ev.kind = K_BADOP; ev.value = IllegalOpCode; ev.last = 1'b1;
          end
        endcase
      end
      S_LEN_HI, S_BLK_HI, S_CODE_HI: begin
        hi_byte_q = b;
        state_q   = parse_state_t'(state_q + 4'd1);
        hit       = 1'b0;
      end
      S_LEN_LO: begin
        data_len_q = word;
        hi_byte_q  = '0;
        state_q    = S_BLK_HI;
        ev.kind    = K_LEN;
        ev.value   = word;
      end
      S_BLK_LO: begin
        hi_byte_q = '0;
        ev.kind   = K_BLOCK;
        ev.value  = word;
        if (opcode_q == OpData && data_len_q != 16'd0) begin
          state_q = S_DATA;
        end else begin
          ev.last = 1'b1;
        end
      end
      S_DATA: begin
        data_cnt_q = data_cnt_q + 16'd1;
        ev.kind    = K_DBYTE;
        ev.value   = {8'h00, b};
        ev.last    = (data_cnt_q == data_len_q);
      end
      S_CODE_LO: begin
        hi_byte_q = '0;
        state_q   = S_STRING;
        ev.kind   = K_CODE;
        ev.value  = word;
      end
      S_FLAG: begin
        state_q  = S_STRING;
        ev.kind  = K_FLAG;
        ev.value = {8'h00, b};
      end
      S_STRING: begin
        if (b == 8'h00) begin
          ev.kind = K_SEND; ev.last = 1'b1;
        end else begin
          ev.kind = K_SBYTE; ev.value = {8'h00, b};
        end
      end
      default: begin
        // opcode high byte, and any phase code that is never entered
        hi_byte_q = b;
        state_q   = S_OP_LO;
        hit       = 1'b0;
      end
    endcase
    if (hit && ev.last) clear_parser();
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatch_count < 40)
      $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    event_t ev;
    event_t want;
    if (!rst_n) begin
      clear_parser();
      expected_events.delete();
      mismatch_count = 0;
    end else begin
      // results first: a byte accepted at this edge cannot show yet
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          report_mismatch("event with nothing pending, opcode", out_packet_opcode, 16'h0);
        end else begin
          want = expected_events.pop_front();
          if (out_packet_opcode !== want.opcode)
            report_mismatch("packet_opcode", out_packet_opcode, want.opcode);
          if (out_item_kind !== want.kind)
            report_mismatch("item_kind", {12'h0, out_item_kind}, {12'h0, want.kind});
          if (out_item_value !== want.value)
            report_mismatch("item_value", out_item_value, want.value);
          if (out_last_of_packet !== want.last)
            report_mismatch("last_of_packet", {15'h0, out_last_of_packet},
                            {15'h0, want.last});
        end
      end
      if (push && !full) begin
        if (deframe_byte(in_byte, ev)) expected_events.push_back(ev);
      end
    end
    events_pending = expected_events.size();
  end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tftpdf_pkg::*;

  // cycles with no item moving on either side before the run is called dead
  localparam int unsigned StallLimit = 2000;
  // length of the forced receiver hold-off
  localparam int unsigned HoldCycles = 80;
  // hold-off starts once the random traffic is under way
  localparam int unsigned HoldFrom   = 60;
  localparam int unsigned ByteTarget = 900;
  // from here on nobody idles
  localparam int unsigned CalmFrom   = 780;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_byte;
  logic        empty;
  logic        pop;
  logic [15:0] out_packet_opcode;
  logic [3:0]  out_item_kind;
  logic [15:0] out_item_value;
  logic        out_last_of_packet;

  int unsigned mismatch_count;
  int unsigned events_pending;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;
  bit          calm;

  tftp_style_packet_deframer_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_byte            (in_byte),
    .empty              (empty),
    .pop                (pop),
    .out_packet_opcode  (out_packet_opcode),
    .out_item_kind      (out_item_kind),
    .out_item_value     (out_item_value),
    .out_last_of_packet (out_last_of_packet)
  );

  tftpdf_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_byte            (in_byte),
    .empty              (empty),
    .pop                (pop),
    .out_packet_opcode  (out_packet_opcode),
    .out_item_kind      (out_item_kind),
    .out_item_value     (out_item_value),
    .out_last_of_packet (out_last_of_packet),
    .mismatch_count     (mismatch_count),
    .events_pending     (events_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // reset held low at the start, then released at a falling edge
  initial begin
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
  end

  // watchdog: counts cycles in which no item moves
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("[tftp_style_packet_deframer_core] ERROR");
        $finish;
      end
    end
  end

  // offer one byte at the falling edge and hold it until taken
  task automatic put_byte(input logic [7:0] b);
    int unsigned gap;
    // random idle burst ahead of the item
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 9);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!(push && !full)) @(posedge clk);
    bytes_sent++;
    if (bytes_sent >= CalmFrom) calm = 1'b1;
    @(negedge clk);
  endtask

  // big-endian word: high byte first
  task automatic put_word(input logic [15:0] w);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endtask

  // zero-ended string of nonzero bytes, now and then left open
  task automatic put_string();
    int unsigned n;
    n = $urandom_range(0, 12);
    repeat (n) put_byte(8'($urandom_range(1, 255)));
    if ($urandom_range(0, 19) != 0) put_byte(8'h00);
  endtask

  // data lengths: mostly short, a few long enough to use the high byte
  function automatic logic [15:0] pick_data_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 6));
    if (r < 95) return 16'($urandom_range(7, 40));
    return 16'($urandom_range(200, 300));
  endfunction

  task automatic random_packet();
    logic [15:0] op;
    logic [15:0] len;
    int unsigned r;
    r = $urandom_range(0, 99);
    // raw noise bytes, parsed as whatever phase the parser is in
    if (r < 4) begin
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (r < 10) op = 16'($urandom_range(0, 65535));
    else if (r < 14) op = 16'($urandom_range(11, 15));
    else op = 16'($urandom_range(1, 10));
    put_word(op);
    case (op)
      OpData: begin
        len = pick_data_len();
        put_word(len);
        put_word(16'($urandom_range(0, 65535)));
        repeat (len) put_byte(8'($urandom_range(0, 255)));
      end
      OpAck: put_word(16'($urandom_range(0, 65535)));
      OpError: begin
        put_word(16'($urandom_range(0, 65535)));
        put_string();
      end
      OpFlag: begin
        put_byte(8'($urandom_range(0, 255)));
        put_string();
      end
      OpRrq, OpWrq, OpStr7, OpStr8: put_string();
      default: ;
    endcase
  endtask

  // receiver: random pop bursts, one forced long hold-off while the sender keeps pushing
  initial begin : sink
    int unsigned gap;
    bit          held_off;
    gap      = 0;
    held_off = 1'b0;
    pop      = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held_off && bytes_sent >= HoldFrom) begin
        held_off = 1'b1;
        pop <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else if (gap > 0) begin
        pop <= 1'b0;
        gap--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        gap = $urandom_range(1, 9) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : source
    push       = 1'b0;
    in_byte    = 8'h00;
    bytes_sent = 0;
    calm       = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);

    // bare packets, both of them
    put_word(OpBare6);
    put_word(OpBare10);
    // bad opcodes: all ones, zero, just past the top
    put_word(16'hFFFF);
    put_word(16'h0000);
    put_word(16'd11);
    // empty data packet ends at its block number
    put_word(OpData);
    put_word(16'h0000);
    put_word(16'hFFFF);
    // one-byte data packet
    put_word(OpData);
    put_word(16'h0001);
    put_word(16'h0000);
    put_byte(8'hFF);
    put_word(OpAck);
    put_word(16'h8001);
    // empty string right after the error code
    put_word(OpError);
    put_word(16'hFFFF);
    put_byte(8'h00);
    put_word(OpFlag);
    put_byte(8'hFF);
    put_byte(8'h01);
    put_byte(8'h00);
    put_word(OpRrq);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_word(OpWrq);
    put_byte(8'h00);
    put_word(OpStr7);
    put_byte(8'h00);
    put_word(OpStr8);
    put_byte(8'h80);
    put_byte(8'h00);

    // random traffic; the receiver's hold-off lands in it and the event queue fills
    while (bytes_sent < ByteTarget) random_packet();
    push <= 1'b0;

    // drain, then let the pipeline settle
    while (events_pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && events_pending == 0) begin
      $display("[tftp_style_packet_deframer_core] OK");
    end else begin
      $display("[tftp_style_packet_deframer_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
